[rtl/mcc2d_pkg.sv]
package mcc2d_pkg;

    // item field widths
    localparam int ACT_W   = 2;
    localparam int CH_W    = 5;
    localparam int POS_W   = 5;
    localparam int SMP_W   = 16;
    localparam int SUM_W   = 40;
    localparam int LAYER_W = 7;

    // configuration register widths
    localparam int IC_W  = 3;
    localparam int DIM_W = 6;
    localparam int KER_W = 4;
    localparam int OC_W  = 4;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 6;

    localparam logic [ACT_W-1:0] ACT_SAMPLE  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_WEIGHT  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_COMPUTE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_INPUT_CHANNELS  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INPUT_WIDTH     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INPUT_HEIGHT    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_WIDTH    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_HEIGHT   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_CHANNELS = 3'd5;

    // effective (clamped) configuration
    typedef struct packed {
        logic [IC_W-1:0]  in_ch;
        logic [DIM_W-1:0] in_w;
        logic [DIM_W-1:0] in_h;
        logic [KER_W-1:0] k_w;
        logic [KER_W-1:0] k_h;
        logic [OC_W-1:0]  out_ch;
    } cfg_t;

    // sequencer to multiply-accumulate unit
    typedef struct packed {
        logic start;
        logic bad;
        logic issue;
        logic last;
    } mac_ctl_t;

endpackage

[rtl/mcc2d_seq.sv]
module mcc2d_seq #(
    parameter int MAX_IN_CHANNELS  = 4,
    parameter int MAX_OUT_CHANNELS = 8,
    parameter int MAX_DIM          = 32,
    parameter int MAX_KERNEL       = 8
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                start_i,
    input  logic [mcc2d_pkg::CH_W-1:0]          ch_i,
    input  logic [mcc2d_pkg::POS_W-1:0]         x_i,
    input  logic [mcc2d_pkg::POS_W-1:0]         y_i,
    input  mcc2d_pkg::cfg_t                     cfg_i,
    input  logic                                retire_i,
    output logic                                idle_o,
    output mcc2d_pkg::mac_ctl_t                 ctl_o,
    output logic [$clog2(MAX_IN_CHANNELS*MAX_DIM*MAX_DIM)-1:0]             img_addr_o,
    output logic [$clog2(MAX_OUT_CHANNELS*MAX_IN_CHANNELS*MAX_KERNEL*MAX_KERNEL)-1:0]
                                                ker_addr_o
);

    localparam int IMG_AW = $clog2(MAX_IN_CHANNELS * MAX_DIM * MAX_DIM);
    localparam int KER_AW = $clog2(MAX_OUT_CHANNELS * MAX_IN_CHANNELS * MAX_KERNEL * MAX_KERNEL);
    localparam int KERNEL_AREA = MAX_KERNEL * MAX_KERNEL;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_WAIT = 2'd2;

    logic [1:0]                       state_reg, state_next;
    logic [mcc2d_pkg::IC_W-1:0]       ic_reg, ic_next;
    logic [mcc2d_pkg::KER_W-1:0]      dx_reg, dx_next;
    logic [mcc2d_pkg::KER_W-1:0]      dy_reg, dy_next;
    logic [mcc2d_pkg::LAYER_W-1:0]    layer_reg, layer_next;
    logic [mcc2d_pkg::POS_W-1:0]      x_reg, x_next;
    logic [mcc2d_pkg::POS_W-1:0]      y_reg, y_next;

    logic bad;
    logic dx_end, dy_end, ic_end;

    // out of range when the channel is not below the output channel count or the kernel window runs off the input
    assign bad = (7'(ch_i) >= 7'(cfg_i.out_ch))
              || (7'(x_i) + 7'(cfg_i.k_w) > 7'(cfg_i.in_w))
              || (7'(y_i) + 7'(cfg_i.k_h) > 7'(cfg_i.in_h));

    assign dx_end = (dx_reg == cfg_i.k_w - 4'd1);
    assign dy_end = (dy_reg == cfg_i.k_h - 4'd1);
    assign ic_end = (ic_reg == cfg_i.in_ch - 3'd1);

    always_comb begin
        state_next = state_reg;
        ic_next    = ic_reg;
        dx_next    = dx_reg;
        dy_next    = dy_reg;
        layer_next = layer_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        ctl_o      = '0;
        case (state_reg)
            ST_IDLE: begin
                if (start_i) begin
                    ctl_o.start = 1'b1;
                    ctl_o.bad   = bad;
                    x_next      = x_i;
                    y_next      = y_i;
                    ic_next     = '0;
                    dx_next     = '0;
                    dy_next     = '0;
                    layer_next  = 7'(ch_i) * 7'(cfg_i.in_ch);
                    state_next  = bad ? ST_WAIT : ST_RUN;
                end
            end
            ST_RUN: begin
                ctl_o.issue = 1'b1;
                ctl_o.last  = dx_end && dy_end && ic_end;
                // advance column, then row, then input channel
                if (!dx_end) begin
                    dx_next = dx_reg + 4'd1;
                end else begin
                    dx_next = '0;
                    if (!dy_end) begin
                        dy_next = dy_reg + 4'd1;
                    end else begin
                        dy_next = '0;
                        if (!ic_end) begin
                            ic_next    = ic_reg + 3'd1;
                            layer_next = layer_reg + 7'd1;
                        end else begin
                            state_next = ST_WAIT;
                        end
                    end
                end
            end
            ST_WAIT: begin
                if (retire_i) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
        ic_reg    <= ic_next;
        dx_reg    <= dx_next;
        dy_reg    <= dy_next;
        layer_reg <= layer_next;
        x_reg     <= x_next;
        y_reg     <= y_next;
    end

    assign idle_o = (state_reg == ST_IDLE);

    assign img_addr_o = IMG_AW'((32'(ic_reg) * MAX_DIM + 32'(y_reg) + 32'(dy_reg)) * MAX_DIM
                              + 32'(x_reg) + 32'(dx_reg));
    assign ker_addr_o = KER_AW'(32'(layer_reg) * KERNEL_AREA + 32'(dy_reg) * MAX_KERNEL
                              + 32'(dx_reg));

endmodule

[rtl/mcc2d_mac.sv]
module mcc2d_mac #(
    parameter int MAX_IN_CHANNELS = 4,
    parameter int MAX_KERNEL      = 8
) (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    input  mcc2d_pkg::mac_ctl_t                      ctl_i,
    input  logic signed [mcc2d_pkg::SMP_W-1:0]       img_q_i,
    input  logic signed [mcc2d_pkg::SMP_W-1:0]       ker_q_i,
    input  logic                                     m_tready_i,
    output logic                                     m_tvalid_o,
    output logic signed [mcc2d_pkg::SUM_W-1:0]       sum_o,
    output logic                                     bad_o,
    output logic                                     retire_o
);

    localparam int PROD_W = 2 * mcc2d_pkg::SMP_W;
    localparam int GROW_W = PROD_W + 1 + $clog2(MAX_IN_CHANNELS * MAX_KERNEL * MAX_KERNEL);
    localparam int ACC_W  = (GROW_W > mcc2d_pkg::SUM_W) ? GROW_W : mcc2d_pkg::SUM_W + 1;
    localparam int HI_W   = ACC_W - mcc2d_pkg::SUM_W + 1;

    logic                         rd_vld_reg, rd_last_reg;
    logic                         prod_vld_reg, prod_last_reg;
    logic signed [PROD_W-1:0]     prod_reg;
    logic signed [ACC_W-1:0]      acc_reg;
    logic                         bad_reg;
    logic                         done_reg;
    logic                         out_vld_reg;
    logic signed [mcc2d_pkg::SUM_W-1:0] sum_reg;
    logic                         out_bad_reg;

    logic [HI_W-1:0]              acc_hi;
    logic signed [mcc2d_pkg::SUM_W-1:0] sat_sum;
    logic                         out_free;

    assign acc_hi = acc_reg[ACC_W-1:mcc2d_pkg::SUM_W-1];

    // clip to the result range when the top bits disagree
    always_comb begin
        if (acc_hi != '0 && acc_hi != '1) begin
            sat_sum = acc_reg[ACC_W-1] ? {1'b1, {(mcc2d_pkg::SUM_W-1){1'b0}}}
                                       : {1'b0, {(mcc2d_pkg::SUM_W-1){1'b1}}};
        end else begin
            sat_sum = acc_reg[mcc2d_pkg::SUM_W-1:0];
        end
    end

    assign out_free = !out_vld_reg || m_tready_i;
    assign retire_o = done_reg && out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_vld_reg   <= 1'b0;
            prod_vld_reg <= 1'b0;
            done_reg     <= 1'b0;
            out_vld_reg  <= 1'b0;
        end else begin
            rd_vld_reg   <= ctl_i.issue;
            prod_vld_reg <= rd_vld_reg;
            if (ctl_i.start) begin
                done_reg <= ctl_i.bad;
            end else if (prod_vld_reg && prod_last_reg) begin
                done_reg <= 1'b1;
            end else if (retire_o) begin
                done_reg <= 1'b0;
            end
            if (retire_o) begin
                out_vld_reg <= 1'b1;
            end else if (m_tready_i) begin
                out_vld_reg <= 1'b0;
            end
        end
        rd_last_reg   <= ctl_i.last;
        prod_last_reg <= rd_last_reg;
        prod_reg      <= img_q_i * ker_q_i;
        if (ctl_i.start) begin
            acc_reg <= '0;
            bad_reg <= ctl_i.bad;
        end else if (prod_vld_reg) begin
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        end
        if (retire_o) begin
            sum_reg     <= sat_sum;
            out_bad_reg <= bad_reg;
        end
    end

    assign m_tvalid_o = out_vld_reg;
    assign sum_o      = sum_reg;
    assign bad_o      = out_bad_reg;

endmodule

[rtl/multichannel_conv2d_unit.sv]
// Multi-channel 2D valid convolution (correlation) engine, Q8.8 in, saturated Q24.16 out.
// Input channel s_*: s_tuser carries the action (load sample, load weight, compute),
// s_tdata the channel, x, y and the Q8.8 value. Loads write the image or kernel store
// and give no result; loads outside the configured sizes are dropped.
// A compute item gives one result on m_*: m_tdata holds the 40-bit saturated sum,
// m_tuser flags a request outside the output size (sum zero).
// A compute walks input_channels * kernel_height * kernel_width products through one
// shared 16x16 multiplier and accumulator, one product per cycle, after reading both
// stores through one registered read port each. Each product passes the store read
// register, the product register and the accumulator; the sum then moves into the
// output register and only then does the block take the next item. A request outside
// the output skips the products. s_tready is low while a compute is under way.
// A finished result waits in the output register while the receiver stalls; loads are
// still taken then, but a further compute holds until its result can move out.
// Synchronous active-low reset returns the configuration registers to their reset
// values and empties the pipeline; store contents are undefined until written.
// Configuration writes are taken on any cycle in which cfg_we is high.
module multichannel_conv2d_unit #(
    parameter int MAX_IN_CHANNELS  = 4,
    parameter int MAX_OUT_CHANNELS = 8,
    parameter int MAX_DIM          = 32,
    parameter int MAX_KERNEL       = 8
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // channel[4:0], pos_x[9:5], pos_y[14:10], sample[30:15], zero[31]
    input  logic [31:0]                           s_tdata,
    // action[1:0]
    input  logic [1:0]                            s_tuser,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // conv_sum[39:0]
    output logic [39:0]                           m_tdata,
    // bad_request[0]
    output logic [0:0]                            m_tuser,
    input  logic                                  cfg_we,
    input  logic [mcc2d_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [mcc2d_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

    localparam int IMG_DEPTH = MAX_IN_CHANNELS * MAX_DIM * MAX_DIM;
    localparam int KERNEL_AREA = MAX_KERNEL * MAX_KERNEL;
    localparam int KER_DEPTH = MAX_OUT_CHANNELS * MAX_IN_CHANNELS * KERNEL_AREA;
    localparam int IMG_AW = $clog2(IMG_DEPTH);
    localparam int KER_AW = $clog2(KER_DEPTH);

    function automatic logic [mcc2d_pkg::CFG_DATA_W-1:0] clamp_cfg(
        input logic [mcc2d_pkg::CFG_DATA_W-1:0] v,
        input int                               hi
    );
        logic [mcc2d_pkg::CFG_DATA_W-1:0] r;
        if (v == '0) begin
            r = mcc2d_pkg::CFG_DATA_W'(1);
        end else if (int'(v) > hi) begin
            r = mcc2d_pkg::CFG_DATA_W'(hi);
        end else begin
            r = v;
        end
        return r;
    endfunction

    logic [mcc2d_pkg::ACT_W-1:0]     action;
    logic [mcc2d_pkg::CH_W-1:0]      channel;
    logic [mcc2d_pkg::POS_W-1:0]     pos_x;
    logic [mcc2d_pkg::POS_W-1:0]     pos_y;
    logic [mcc2d_pkg::SMP_W-1:0]     sample;

    assign action  = s_tuser;
    assign channel = s_tdata[4:0];
    assign pos_x   = s_tdata[9:5];
    assign pos_y   = s_tdata[14:10];
    assign sample  = s_tdata[30:15];

    mcc2d_pkg::cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.in_ch  <= mcc2d_pkg::IC_W'(clamp_cfg(6'd1, MAX_IN_CHANNELS));
            cfg_reg.in_w   <= mcc2d_pkg::DIM_W'(clamp_cfg(6'd32, MAX_DIM));
            cfg_reg.in_h   <= mcc2d_pkg::DIM_W'(clamp_cfg(6'd32, MAX_DIM));
            cfg_reg.k_w    <= mcc2d_pkg::KER_W'(clamp_cfg(6'd3, MAX_KERNEL));
            cfg_reg.k_h    <= mcc2d_pkg::KER_W'(clamp_cfg(6'd3, MAX_KERNEL));
            cfg_reg.out_ch <= mcc2d_pkg::OC_W'(clamp_cfg(6'd1, MAX_OUT_CHANNELS));
        end else if (cfg_we) begin
            // hold the effective value, clamped to [1, maximum]
            case (cfg_index)
                mcc2d_pkg::CFG_INPUT_CHANNELS:
                    cfg_reg.in_ch <= mcc2d_pkg::IC_W'(clamp_cfg(
                        6'(cfg_wdata[mcc2d_pkg::IC_W-1:0]), MAX_IN_CHANNELS));
                mcc2d_pkg::CFG_INPUT_WIDTH:
                    cfg_reg.in_w <= mcc2d_pkg::DIM_W'(clamp_cfg(cfg_wdata, MAX_DIM));
                mcc2d_pkg::CFG_INPUT_HEIGHT:
                    cfg_reg.in_h <= mcc2d_pkg::DIM_W'(clamp_cfg(cfg_wdata, MAX_DIM));
                mcc2d_pkg::CFG_KERNEL_WIDTH:
                    cfg_reg.k_w <= mcc2d_pkg::KER_W'(clamp_cfg(
                        6'(cfg_wdata[mcc2d_pkg::KER_W-1:0]), MAX_KERNEL));
                mcc2d_pkg::CFG_KERNEL_HEIGHT:
                    cfg_reg.k_h <= mcc2d_pkg::KER_W'(clamp_cfg(
                        6'(cfg_wdata[mcc2d_pkg::KER_W-1:0]), MAX_KERNEL));
                mcc2d_pkg::CFG_OUTPUT_CHANNELS:
                    cfg_reg.out_ch <= mcc2d_pkg::OC_W'(clamp_cfg(
                        6'(cfg_wdata[mcc2d_pkg::OC_W-1:0]), MAX_OUT_CHANNELS));
                default: begin
                end
            endcase
        end
    end

    logic                         accept;
    logic                         seq_idle;
    logic                         img_we, ker_we;
    logic [IMG_AW-1:0]            img_waddr, img_raddr;
    logic [KER_AW-1:0]            ker_waddr, ker_raddr;
    logic signed [mcc2d_pkg::SMP_W-1:0] img_q_reg, ker_q_reg;
    mcc2d_pkg::mac_ctl_t          mac_ctl;
    logic                         retire;
    logic signed [mcc2d_pkg::SUM_W-1:0] conv_sum;
    logic                         bad_request;

    assign s_tready = seq_idle;
    assign accept   = s_tvalid && s_tready;

    // drop loads outside the configured sizes
    assign img_we = accept && (action == mcc2d_pkg::ACT_SAMPLE)
                 && (5'(channel) < 5'(cfg_reg.in_ch))
                 && (6'(pos_x) < cfg_reg.in_w) && (6'(pos_y) < cfg_reg.in_h);
    assign ker_we = accept && (action == mcc2d_pkg::ACT_WEIGHT)
                 && (7'(channel) < 7'(cfg_reg.out_ch) * 7'(cfg_reg.in_ch))
                 && (5'(pos_x) < 5'(cfg_reg.k_w)) && (5'(pos_y) < 5'(cfg_reg.k_h));

    assign img_waddr = IMG_AW'((32'(channel) * MAX_DIM + 32'(pos_y)) * MAX_DIM + 32'(pos_x));
    assign ker_waddr = KER_AW'(32'(channel) * KERNEL_AREA + 32'(pos_y) * MAX_KERNEL
                             + 32'(pos_x));

    logic [mcc2d_pkg::SMP_W-1:0] img_mem [IMG_DEPTH];
    logic [mcc2d_pkg::SMP_W-1:0] ker_mem [KER_DEPTH];

    always_ff @(posedge aclk) begin
        if (img_we) begin
            img_mem[img_waddr] <= sample;
        end
        img_q_reg <= img_mem[img_raddr];
    end

    always_ff @(posedge aclk) begin
        if (ker_we) begin
            ker_mem[ker_waddr] <= sample;
        end
        ker_q_reg <= ker_mem[ker_raddr];
    end

    mcc2d_seq #(
        .MAX_IN_CHANNELS (MAX_IN_CHANNELS),
        .MAX_OUT_CHANNELS(MAX_OUT_CHANNELS),
        .MAX_DIM         (MAX_DIM),
        .MAX_KERNEL      (MAX_KERNEL)
    ) u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start_i   (accept && (action == mcc2d_pkg::ACT_COMPUTE)),
        .ch_i      (channel),
        .x_i       (pos_x),
        .y_i       (pos_y),
        .cfg_i     (cfg_reg),
        .retire_i  (retire),
        .idle_o    (seq_idle),
        .ctl_o     (mac_ctl),
        .img_addr_o(img_raddr),
        .ker_addr_o(ker_raddr)
    );

    mcc2d_mac #(
        .MAX_IN_CHANNELS(MAX_IN_CHANNELS),
        .MAX_KERNEL     (MAX_KERNEL)
    ) u_mac (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl_i     (mac_ctl),
        .img_q_i   (img_q_reg),
        .ker_q_i   (ker_q_reg),
        .m_tready_i(m_tready),
        .m_tvalid_o(m_tvalid),
        .sum_o     (conv_sum),
        .bad_o     (bad_request),
        .retire_o  (retire)
    );

    assign m_tdata = conv_sum;
    assign m_tuser = bad_request;

    a_compute_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && action == mcc2d_pkg::ACT_COMPUTE) |=> !s_tready)
        else $error("compute accepted but input still ready");

    a_result_from_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (retire) |-> !seq_idle)
        else $error("result retired while sequencer idle");

    a_no_write_in_compute: assert property (@(posedge aclk) disable iff (!aresetn)
        (img_we || ker_we) |-> seq_idle)
        else $error("store written during a compute");

endmodule
